### rtl/qts_pkg.sv
// Package: item types, mode and result codes for the quoted token splitter.
`timescale 1ns / 1ps
`default_nettype none

package qts_pkg;

  // Default depth of the result queue (must be at least 2)
  localparam int QTS_FIFO_DEPTH = 4;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_PLAIN   = 3'd1,
    MODE_BODY    = 3'd2,
    MODE_ESC     = 3'd3,
    MODE_HEX1    = 3'd4,
    MODE_HEX2    = 3'd5,
    MODE_CLOSED  = 3'd6,
    MODE_DROP    = 3'd7
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNTERMINATED = 2'd1,
    ERR_BAD_HEX      = 2'd2,
    ERR_GARBAGE      = 2'd3
  } err_t;

  // One input item
  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } in_item_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       quoted;
    err_t       error_code;
    logic       last;
  } res_item_t;

  // Results of one item, handed from scanner to queue
  typedef struct packed {
    logic [1:0] count;
    res_item_t  res0;
    res_item_t  res1;
  } push_t;

endpackage

`default_nettype wire

### rtl/quoted_token_splitter.sv
// Top level: quoted token splitter, scanner feeding a small result queue.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------
//  byte    | in  | byte_valid/byte_stall  | byte_item (ch, end_mark)
//  res     | out | res_valid/res_stall    | res_item (kind, data, quoted,
//          |     |                        |   error_code, last)
//
// One byte item per cycle while byte_stall is low; an accepted item waits
// in the input register until the queue has room. An end item gives one or
// two results: a done, preceded by a token end or an error when a token or
// quote is still open. Throughput is set by the queue's one output port.
// rst is synchronous and clears mode, input register and queue.
// byte_stall rises when the input register holds an item and the queue
// lacks room for two results.
`timescale 1ns / 1ps
`default_nettype none

module quoted_token_splitter #(
  parameter int FifoDepth = qts_pkg::QTS_FIFO_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire qts_pkg::in_item_t  byte_item,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output qts_pkg::res_item_t      res_item
);

  qts_pkg::push_t push;
  logic           room;

  // Mode machine
  qts_scanner u_scanner (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .room       (room),
    .push       (push)
  );

  // Result queue
  qts_res_fifo #(
    .Depth (FifoDepth)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

`default_nettype wire

### rtl/qts_scanner.sv
// Scanner: input register, mode machine and result forming for each item.
`timescale 1ns / 1ps
`default_nettype none

module qts_scanner (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             byte_valid,
  output logic                  byte_stall,
  input  wire qts_pkg::in_item_t byte_item,
  input  wire logic             room,
  output qts_pkg::push_t        push
);

  // Hex digit value; bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

  logic                in_v;
  qts_pkg::in_item_t   in_item;
  qts_pkg::mode_t      mode, mode_next;
  logic                quote_dbl, quote_dbl_next;
  logic [3:0]          hex_hi, hex_hi_next;
  logic                advance;
  logic                is_ws;
  logic                is_quote;
  logic [7:0]          c;
  logic [4:0]          hv;
  qts_pkg::res_item_t  r0, r1;
  logic [1:0]          n;

  assign c        = in_item.ch;
  assign is_ws    = (c == 8'h20) || (c inside {[8'h09:8'h0d]});
  assign is_quote = quote_dbl ? (c == 8'h22) : (c == 8'h27);
  assign hv       = hex_value(c);
  assign advance  = in_v && room;
  assign byte_stall = in_v && !room;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_item <= byte_item;
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= qts_pkg::MODE_BETWEEN;
      quote_dbl <= 1'b0;
      hex_hi    <= 4'd0;
    end else if (advance) begin
      mode      <= mode_next;
      quote_dbl <= quote_dbl_next;
      hex_hi    <= hex_hi_next;
    end
  end

  // Next state
  always_comb begin
    mode_next      = mode;
    quote_dbl_next = quote_dbl;
    hex_hi_next    = hex_hi;
    if (in_item.end_mark) begin
      mode_next      = qts_pkg::MODE_BETWEEN;
      quote_dbl_next = 1'b0;
      hex_hi_next    = 4'd0;
    end else begin
      case (mode)
        qts_pkg::MODE_BETWEEN: begin
          if (c == 8'h22 || c == 8'h27) begin
            quote_dbl_next = (c == 8'h22);
            mode_next      = qts_pkg::MODE_BODY;
          end else if (!is_ws) begin
            mode_next = qts_pkg::MODE_PLAIN;
          end
        end
        qts_pkg::MODE_PLAIN: begin
          if (is_ws) mode_next = qts_pkg::MODE_BETWEEN;
        end
        qts_pkg::MODE_BODY: begin
          if (is_quote) mode_next = qts_pkg::MODE_CLOSED;
          else if (c == 8'h5c) mode_next = qts_pkg::MODE_ESC;
        end
        qts_pkg::MODE_ESC: begin
          mode_next = (c == 8'h78) ? qts_pkg::MODE_HEX1 : qts_pkg::MODE_BODY;
        end
        qts_pkg::MODE_HEX1: begin
          if (hv[4]) begin
            mode_next = qts_pkg::MODE_DROP;
          end else begin
            hex_hi_next = hv[3:0];
            mode_next   = qts_pkg::MODE_HEX2;
          end
        end
        qts_pkg::MODE_HEX2: begin
          if (hv[4]) begin
            mode_next = qts_pkg::MODE_DROP;
          end else begin
            hex_hi_next = 4'd0;
            mode_next   = qts_pkg::MODE_BODY;
          end
        end
        qts_pkg::MODE_CLOSED: begin
          mode_next = is_ws ? qts_pkg::MODE_BETWEEN : qts_pkg::MODE_DROP;
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  // Results of the item
  always_comb begin
    r0 = '{kind: qts_pkg::KIND_BYTE, data: 8'd0, quoted: 1'b0,
           error_code: qts_pkg::ERR_NONE, last: 1'b0};
    r1 = '{kind: qts_pkg::KIND_DONE, data: 8'd0, quoted: 1'b0,
           error_code: qts_pkg::ERR_NONE, last: 1'b1};
    n  = 2'd0;
    if (in_item.end_mark) begin
      case (mode)
        qts_pkg::MODE_PLAIN: begin
          r0.kind = qts_pkg::KIND_END;
          n       = 2'd2;
        end
        qts_pkg::MODE_BODY, qts_pkg::MODE_ESC, qts_pkg::MODE_HEX1,
        qts_pkg::MODE_HEX2: begin
          r0.kind       = qts_pkg::KIND_ERROR;
          r0.error_code = qts_pkg::ERR_UNTERMINATED;
          n             = 2'd2;
        end
        default: begin
          r0.kind = qts_pkg::KIND_DONE;
          n       = 2'd1;
        end
      endcase
    end else begin
      case (mode)
        qts_pkg::MODE_BETWEEN: begin
          if (!is_ws && c != 8'h22 && c != 8'h27) begin
            r0.data = c;
            n       = 2'd1;
          end
        end
        qts_pkg::MODE_PLAIN: begin
          if (is_ws) r0.kind = qts_pkg::KIND_END;
          else r0.data = c;
          n = 2'd1;
        end
        qts_pkg::MODE_BODY: begin
          r0.quoted = 1'b1;
          if (is_quote) begin
            r0.kind = qts_pkg::KIND_END;
            n       = 2'd1;
          end else if (c != 8'h5c) begin
            r0.data = c;
            n       = 2'd1;
          end
        end
        qts_pkg::MODE_ESC: begin
          r0.quoted = 1'b1;
          if (c != 8'h78) begin
            n = 2'd1;
            case (c)
              8'h61:   r0.data = 8'd7;
              8'h62:   r0.data = 8'd8;
              8'h66:   r0.data = 8'd12;
              8'h6e:   r0.data = 8'd10;
              8'h72:   r0.data = 8'd13;
              8'h74:   r0.data = 8'd9;
              8'h76:   r0.data = 8'd11;
              default: r0.data = c;
            endcase
          end
        end
        qts_pkg::MODE_HEX1: begin
          if (hv[4]) begin
            r0.kind       = qts_pkg::KIND_ERROR;
            r0.error_code = qts_pkg::ERR_BAD_HEX;
            n             = 2'd1;
          end
        end
        qts_pkg::MODE_HEX2: begin
          n = 2'd1;
          if (hv[4]) begin
            r0.kind       = qts_pkg::KIND_ERROR;
            r0.error_code = qts_pkg::ERR_BAD_HEX;
          end else begin
            r0.data   = {hex_hi, hv[3:0]};
            r0.quoted = 1'b1;
          end
        end
        qts_pkg::MODE_CLOSED: begin
          if (!is_ws) begin
            r0.kind       = qts_pkg::KIND_ERROR;
            r0.error_code = qts_pkg::ERR_GARBAGE;
            n             = 2'd1;
          end
        end
        default: begin
          n = 2'd0;
        end
      endcase
    end
    // first result is last when it stands alone
    r0.last = (n == 2'd1);
  end

  assign push.count = advance ? n : 2'd0;
  assign push.res0  = r0;
  assign push.res1  = r1;

endmodule

`default_nettype wire

### rtl/qts_res_fifo.sv
// Result queue: takes up to two results a cycle, hands out one unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module qts_res_fifo #(
  parameter int Depth = qts_pkg::QTS_FIFO_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire qts_pkg::push_t      push,
  output logic                     room,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output qts_pkg::res_item_t       res_item
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  qts_pkg::res_item_t mem [Depth];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [CW-1:0] count;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(Depth - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign wr_ptr1   = ptr_inc(wr_ptr);
  assign res_valid = (count != '0);
  assign res_item  = mem[rd_ptr];
  assign pop       = res_valid && !res_stall;
  assign room      = (count <= CW'(Depth - 2));

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1] <= push.res1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.count == 2'd1) wr_ptr <= wr_ptr1;
      else if (push.count == 2'd2) wr_ptr <= ptr_inc(wr_ptr1);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      count <= CW'(count + CW'(push.count) - CW'(pop));
    end
  end

endmodule

`default_nettype wire
